[hw/rtl/hnm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_pkg: shared types and constants of the height map to normal map core
// Widths of the sample path, the job word passed from front to back, and the
// state encodings of the two sequencers.
// ---------------------------------------------------------------------------
package hnm_pkg;

    localparam int MAX_SIZE    = 1024;
    localparam int HEIGHT_BITS = 16;
    localparam int COL_W       = $clog2(MAX_SIZE);
    localparam int SIDE_W      = COL_W + 1;
    localparam int DIFF_W      = HEIGHT_BITS + 1;
    localparam int GRAD_W      = HEIGHT_BITS + COL_W + 2;
    localparam int SQ_W        = 2 * GRAD_W;
    // The search compares N*k^2 against A^2 * 128^2 for k up to 255.
    localparam int Q_SHIFT     = 14;
    localparam int ACC_W       = SQ_W + Q_SHIFT + 19;
    localparam int KZ_SQ_SHIFT = 2 * (HEIGHT_BITS + 2);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef struct packed {
        logic [COL_W-1:0]       x;
        logic [COL_W-1:0]       y;
        logic [HEIGHT_BITS-1:0] ua;
        logic [HEIGHT_BITS-1:0] ub;
        logic [HEIGHT_BITS-1:0] va;
        logic [HEIGHT_BITS-1:0] vb;
        logic                   u_edge;
        logic                   v_edge;
        logic [SIDE_W-1:0]      side;
        logic                   last;
        logic                   eof;
    } hnm_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hnm_q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH,
        F_WRITE
    } hnm_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIFF,
        B_GRAD,
        B_SQR,
        B_NORM,
        B_SRCH,
        B_DONE
    } hnm_back_state_t;

endpackage

[hw/rtl/heightmap_normal_map_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heightmap_normal_map_core: height image to RGB normal map
// Central-difference gradients with one-sided edges, normalized and
// quantized to 8 bits per component, emitted one row behind the input.
// ---------------------------------------------------------------------------
//
//  channel   dir  word contents (lowest bit first)
//  s_*       in   height[15:0]
//  m_*       out  pixel_col[9:0], pixel_row[19:10], red[27:20], green[35:28],
//                 blue[43:36], zero[47:44]; tlast = last_of_run, tuser = end_of_frame
//  cfg_*     in   image_size[10:0], written when cfg_wr_en is high
//
// Each input word passes through the intake sequencer (accept, row-store reads,
// three job slots, row-store write); a full job queue stalls the push. Each
// output word passes through the arithmetic unit (pop, difference, gradient,
// square, norm, eight search steps, output load), and the output load waits
// while a stalled receiver still holds the output register. A bottom-row word
// other than the first yields two jobs and the bottom-right word three. A
// four-entry job queue and the output register let intake and result delivery
// stall apart.
// Reset is synchronous and active low; the row stores are not cleared.
//
module heightmap_normal_map_core import hnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,  // image_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // height
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // pixel_col, pixel_row, red, green, blue
    output logic        m_tlast,      // last_of_run
    output logic        m_tuser       // end_of_frame
);

    hnm_q_status_t q_status;
    hnm_job_t      push_job, pop_job;
    logic          push, pop;

    // The front tracks the raster position and turns each word into pixel jobs.
    hnm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_height    (s_tdata),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    // Jobs wait here while the back is busy.
    hnm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // The back computes one normal per job and holds it in the output register.
    hnm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop      (pop),
        .pop_job  (pop_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hw/rtl/hnm_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/hnm_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_front: sample intake and pixel classification
// Tracks the raster position, fetches the neighbor heights from the two row
// stores, and issues one job per normal-map pixel that the sample completes.
// ---------------------------------------------------------------------------
module hnm_front import hnm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [SIDE_W-1:0]      cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [HEIGHT_BITS-1:0] s_height,
    input  hnm_q_status_t          q_status,
    output logic                   push,
    output hnm_job_t               push_job
);

    hnm_front_state_t       state_reg, state_next;
    logic [SIDE_W-1:0]      size_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic [COL_W-1:0]       col_reg, row_reg;
    logic [COL_W-1:0]       c_reg, r_reg;
    logic [HEIGHT_BITS-1:0] cur_reg;
    logic [2:0]             cnt_reg;
    logic [1:0]             sel_reg;
    logic [HEIGHT_BITS-1:0] prev_win_reg [4];
    logic [HEIGHT_BITS-1:0] rbp_win_reg [2];

    logic [SIDE_W-1:0]      side_c;
    logic                   restart;
    logic [2:0]             emit;
    logic                   c_is_last, r_is_last;
    logic [1:0]             win_idx;
    logic [COL_W-1:0]       prev_rd_addr, rbp_rd_addr;
    logic [HEIGHT_BITS-1:0] prev_rd_data, rbp_rd_data;
    logic                   ram_we;
    logic [SIDE_W-1:0]      col_inc;

    always_comb begin
        if (size_reg < SIDE_W'(2)) begin
            side_c = SIDE_W'(2);
        end else if (size_reg > SIDE_W'(MAX_SIZE)) begin
            side_c = SIDE_W'(MAX_SIZE);
        end else begin
            side_c = size_reg;
        end
    end

    assign restart   = ({1'b0, col_reg} >= side_c) || ({1'b0, row_reg} >= side_c);
    assign c_is_last = ({1'b0, c_reg} == side_reg - SIDE_W'(1));
    assign r_is_last = ({1'b0, r_reg} == side_reg - SIDE_W'(1));
    assign emit[0]   = (r_reg != '0);
    assign emit[1]   = r_is_last && (c_reg != '0);
    assign emit[2]   = r_is_last && c_is_last;
    assign win_idx   = 2'(cnt_reg - 3'd1);
    assign col_inc   = {1'b0, c_reg} + SIDE_W'(1);

    assign prev_rd_addr = c_reg + COL_W'(cnt_reg) - COL_W'(2);
    assign rbp_rd_addr  = c_reg + COL_W'(cnt_reg) - COL_W'(1);

    hnm_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_SIZE)) u_prev_row (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (c_reg),
        .wr_data (cur_reg),
        .rd_addr (prev_rd_addr),
        .rd_data (prev_rd_data)
    );

    hnm_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_SIZE)) u_rbp_row (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (c_reg),
        .wr_data (prev_win_reg[2]),
        .rd_addr (rbp_rd_addr),
        .rd_data (rbp_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    state_next = F_READ;
                end
            end
            F_READ: begin
                if (cnt_reg == 3'd4) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if ((sel_reg == 2'd2) && (!emit[sel_reg] || !q_status.full)) begin
                    state_next = F_WRITE;
                end
            end
            F_WRITE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == F_IDLE);
        push     = (state_reg == F_PUSH) && emit[sel_reg] && !q_status.full;
        ram_we   = (state_reg == F_WRITE);
    end

    // Job contents for the pixel selected by sel_reg.
    always_comb begin
        push_job        = '0;
        push_job.side   = side_reg;
        unique case (sel_reg)
            2'd0: begin
                // Pixel above the current sample.
                push_job.x    = c_reg;
                push_job.y    = r_reg - COL_W'(1);
                push_job.last = !emit[1] && !emit[2];
                if (c_reg == '0) begin
                    push_job.ua     = prev_win_reg[2];
                    push_job.ub     = prev_win_reg[3];
                    push_job.u_edge = 1'b1;
                end else if (c_is_last) begin
                    push_job.ua     = rbp_win_reg[0];
                    push_job.ub     = prev_win_reg[2];
                    push_job.u_edge = 1'b1;
                end else begin
                    push_job.ua = rbp_win_reg[0];
                    push_job.ub = prev_win_reg[3];
                end
                if (r_reg == COL_W'(1)) begin
                    push_job.va     = prev_win_reg[2];
                    push_job.vb     = cur_reg;
                    push_job.v_edge = 1'b1;
                end else begin
                    push_job.va = rbp_win_reg[1];
                    push_job.vb = cur_reg;
                end
            end
            2'd1: begin
                // Bottom row, pixel left of the current sample.
                push_job.x      = c_reg - COL_W'(1);
                push_job.y      = r_reg;
                push_job.last   = !emit[2];
                push_job.va     = rbp_win_reg[0];
                push_job.vb     = prev_win_reg[1];
                push_job.v_edge = 1'b1;
                push_job.ub     = cur_reg;
                if (c_reg == COL_W'(1)) begin
                    push_job.ua     = prev_win_reg[1];
                    push_job.u_edge = 1'b1;
                end else begin
                    push_job.ua = prev_win_reg[0];
                end
            end
            2'd2: begin
                // Bottom-right corner.
                push_job.x      = c_reg;
                push_job.y      = r_reg;
                push_job.last   = 1'b1;
                push_job.eof    = 1'b1;
                push_job.ua     = prev_win_reg[1];
                push_job.ub     = cur_reg;
                push_job.u_edge = 1'b1;
                push_job.va     = prev_win_reg[2];
                push_job.vb     = cur_reg;
                push_job.v_edge = 1'b1;
            end
            default: begin
                push_job.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            size_reg  <= SIDE_W'(MAX_SIZE);
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                F_IDLE: begin
                    cnt_reg <= '0;
                    sel_reg <= '0;
                end
                F_READ: begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
                F_PUSH: begin
                    if (!emit[sel_reg] || !q_status.full) begin
                        sel_reg <= sel_reg + 2'd1;
                    end
                end
                F_WRITE: begin
                    if (col_inc >= side_reg) begin
                        col_reg <= '0;
                        row_reg <= r_is_last ? '0 : r_reg + COL_W'(1);
                    end else begin
                        col_reg <= col_inc[COL_W-1:0];
                        row_reg <= r_reg;
                    end
                end
                default: begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_tvalid) begin
            side_reg <= side_c;
            cur_reg  <= s_height;
            c_reg    <= restart ? '0 : col_reg;
            r_reg    <= restart ? '0 : row_reg;
        end
        if (state_reg == F_READ && cnt_reg != 3'd0) begin
            prev_win_reg[win_idx] <= prev_rd_data;
            if (cnt_reg <= 3'd2) begin
                rbp_win_reg[win_idx[0]] <= rbp_rd_data;
            end
        end
    end

endmodule

[hw/rtl/hnm_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_queue: job FIFO between front and back
// A few entries of pixel jobs so that intake and arithmetic stall apart.
// ---------------------------------------------------------------------------
module hnm_queue import hnm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hnm_job_t      push_job,
    input  logic          pop,
    output hnm_job_t      pop_job,
    output hnm_q_status_t status
);

    hnm_job_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign status.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/hnm_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_back: gradient, normalization and quantization of one pixel job
// Forms the scaled gradients, their squares and the norm, then finds each
// quantized component with an eight-step square-root style search.
// ---------------------------------------------------------------------------
module hnm_back import hnm_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  hnm_q_status_t q_status,
    output logic          pop,
    input  hnm_job_t      pop_job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);

    hnm_back_state_t      state_reg, state_next;
    hnm_job_t             job_reg;
    logic signed [DIFF_W-1:0] du_reg, dv_reg;
    logic [GRAD_W-1:0]    gu_mag_reg, gv_mag_reg;
    logic                 u_neg_reg, v_neg_reg;
    logic [SQ_W-1:0]      gu2_reg, gv2_reg;
    logic [ACC_W-1:0]     p_reg [3];
    logic [ACC_W-1:0]     a_reg [3];
    logic [ACC_W-1:0]     b_reg [3];
    logic [ACC_W-1:0]     x_reg [3];
    logic [7:0]           t_reg [3];
    logic                 neg_reg [3];
    logic [2:0]           step_reg;
    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;
    logic                 out_last_reg, out_eof_reg;

    logic                 slot_free;
    logic signed [DIFF_W+SIDE_W:0] pu, pv;
    logic [GRAD_W-1:0]    mu, mv;
    logic [ACC_W-1:0]     norm;
    logic [ACC_W-1:0]     trial [3];
    logic                 ok [3];
    logic [7:0]           q [3];

    function automatic logic [7:0] quantize(input logic [7:0] t, input logic neg);
        logic [7:0] r;
        if (neg) begin
            r = (t >= 8'd127) ? 8'd0 : 8'd127 - t;
        end else begin
            r = (t >= 8'd128) ? 8'd255 : 8'd128 + t;
        end
        return r;
    endfunction

    assign slot_free = !out_valid_reg || m_tready;

    assign pu = $signed(du_reg) * $signed({1'b0, job_reg.side});
    assign pv = $signed(dv_reg) * $signed({1'b0, job_reg.side});
    assign mu = pu[DIFF_W+SIDE_W] ? GRAD_W'(-pu) : GRAD_W'(pu);
    assign mv = pv[DIFF_W+SIDE_W] ? GRAD_W'(-pv) : GRAD_W'(pv);
    assign norm = ACC_W'(gu2_reg) + ACC_W'(gv2_reg) + (ACC_W'(1) << KZ_SQ_SHIFT);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i] = p_reg[i] + a_reg[i] + b_reg[i];
            ok[i]    = neg_reg[i] ? (trial[i] < x_reg[i]) : (trial[i] <= x_reg[i]);
            q[i]     = quantize(t_reg[i], neg_reg[i]);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_status.empty) state_next = B_DIFF;
            B_DIFF: state_next = B_GRAD;
            B_GRAD: state_next = B_SQR;
            B_SQR:  state_next = B_NORM;
            B_NORM: state_next = B_SRCH;
            B_SRCH: if (step_reg == 3'd0) state_next = B_DONE;
            B_DONE: if (slot_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        pop      = (state_reg == B_IDLE) && !q_status.empty;
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
        m_tuser  = out_eof_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_DONE && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= pop_job;
        end
        if (state_reg == B_DIFF) begin
            du_reg <= $signed({1'b0, job_reg.ua}) - $signed({1'b0, job_reg.ub});
            dv_reg <= $signed({1'b0, job_reg.va}) - $signed({1'b0, job_reg.vb});
        end
        if (state_reg == B_GRAD) begin
            gu_mag_reg <= job_reg.u_edge ? (mu << 1) : mu;
            gv_mag_reg <= job_reg.v_edge ? (mv << 1) : mv;
            u_neg_reg  <= du_reg[DIFF_W-1];
            v_neg_reg  <= dv_reg[DIFF_W-1];
        end
        if (state_reg == B_SQR) begin
            gu2_reg <= gu_mag_reg * gu_mag_reg;
            gv2_reg <= gv_mag_reg * gv_mag_reg;
        end
        if (state_reg == B_NORM) begin
            x_reg[0]   <= ACC_W'(gu2_reg) << Q_SHIFT;
            x_reg[1]   <= ACC_W'(gv2_reg) << Q_SHIFT;
            x_reg[2]   <= ACC_W'(1) << (KZ_SQ_SHIFT + Q_SHIFT);
            neg_reg[0] <= u_neg_reg;
            neg_reg[1] <= v_neg_reg;
            neg_reg[2] <= 1'b0;
            step_reg   <= 3'd7;
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= '0;
                a_reg[i] <= '0;
                b_reg[i] <= norm << Q_SHIFT;
                t_reg[i] <= '0;
            end
        end
        if (state_reg == B_SRCH) begin
            // b_reg holds N*2^(2s), a_reg holds N*t*2^(s+1), p_reg holds N*t^2.
            step_reg <= step_reg - 3'd1;
            for (int i = 0; i < 3; i++) begin
                b_reg[i] <= b_reg[i] >> 2;
                if (ok[i]) begin
                    p_reg[i]           <= trial[i];
                    a_reg[i]           <= (a_reg[i] >> 1) + b_reg[i];
                    t_reg[i][step_reg] <= 1'b1;
                end else begin
                    a_reg[i] <= a_reg[i] >> 1;
                end
            end
        end
        if (state_reg == B_DONE && slot_free) begin
            out_data_reg <= {4'b0, q[2], q[1], q[0], job_reg.y, job_reg.x};
            out_last_reg <= job_reg.last;
            out_eof_reg  <= job_reg.eof;
        end
    end

endmodule

[hw/rtl/hnm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnm_checker: port-level checks of the normal map core
// Watches the result channel for reset behavior, holding under stalls and frame-end consistency.
// ---------------------------------------------------------------------------
module hnm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end word is not last of its run");

    a_eof_on_diagonal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[9:0] == m_tdata[19:10]))
        else $error("frame end word is not the corner pixel");

endmodule

bind heightmap_normal_map_core hnm_checker u_hnm_checker (.*);

[tb/heightmap_normal_map_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heightmap_normal_map_core_test: self-checking bench of the normal map core
// A short stimulus table and then random height frames at several image
// sizes. Every output word is checked against a local gradient and
// normalization model, under random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module heightmap_normal_map_core_test;
    import hnm_pkg::*;

    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lst;
        logic       eof;
    } normal_px_t;

    typedef struct {
        bit          wr;     // write image_size before this word
        logic [10:0] size;
        logic [15:0] height;
        bit          flat;   // a flat image gives the straight-up normal
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    heightmap_normal_map_core i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // Model state: the two row stores, the raster counters and the size.
    logic [15:0] row_above [MAX_SIZE];
    logic [15:0] row_two_above [MAX_SIZE];
    int unsigned col_cnt;
    int unsigned row_cnt;
    logic [10:0] size_reg;
    int unsigned side_now;
    int unsigned word_col, word_row;
    logic [15:0] word_height;

    normal_px_t  pending_normals[$];
    int          err_cnt;
    int          words_sent;
    int          normals_seen;
    int          burst_left;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Height at (x,y), where y is the current row or one of the two above.
    function automatic longint sample_at(int unsigned x, int unsigned y);
        int unsigned d;
        d = word_row - y;
        if (x >= MAX_SIZE) x = 0;
        if (d == 0) return (x == word_col) ? word_height : row_above[x];
        if (d == 1) return (x < word_col) ? row_two_above[x] : row_above[x];
        return row_two_above[x];
    endfunction

    // Quantized component: 128 + floor(128*A/sqrt(N)), found with squares.
    function automatic logic [7:0] quantize(longint a, logic [127:0] n);
        logic [127:0] m;
        logic [127:0] asq;
        int           t;
        t = 0;
        m = (a < 0) ? -a : a;
        asq = (m * m) << 14;
        if (a >= 0) begin
            for (int k = 1; k <= 128; k++)
                if (n * (k * k) <= asq) t = k;
            return (t >= 128) ? 8'd255 : 8'(128 + t);
        end
        for (int k = 0; k < 128; k++)
            if (n * (k * k) < asq) t++;
        return 8'(128 - t);
    endfunction

    function automatic normal_px_t normal_of(int unsigned x, int unsigned y);
        normal_px_t   p;
        longint       du, dv, gu, gv, mu, mv, kz;
        logic [127:0] mgu, mgv, n;
        kz = longint'(1) << (HEIGHT_BITS + 2);
        mu = 1;
        mv = 1;
        if (x == 0) begin
            du = sample_at(0, y) - sample_at(1, y);
            mu = 2;
        end else if (x == side_now - 1) begin
            du = sample_at(x - 1, y) - sample_at(x, y);
            mu = 2;
        end else begin
            du = sample_at(x - 1, y) - sample_at(x + 1, y);
        end
        if (y == 0) begin
            dv = sample_at(x, 0) - sample_at(x, 1);
            mv = 2;
        end else if (y == side_now - 1) begin
            dv = sample_at(x, y - 1) - sample_at(x, y);
            mv = 2;
        end else begin
            dv = sample_at(x, y - 1) - sample_at(x, y + 1);
        end
        gu = du * longint'(side_now) * mu;
        gv = dv * longint'(side_now) * mv;
        mgu = (gu < 0) ? -gu : gu;
        mgv = (gv < 0) ? -gv : gv;
        n = mgu * mgu + mgv * mgv + (128'(kz) * 128'(kz));
        p.col   = x[9:0];
        p.row   = y[9:0];
        p.red   = quantize(gu, n);
        p.green = quantize(gv, n);
        p.blue  = quantize(kz, n);
        p.lst   = 1'b0;
        p.eof   = (x == side_now - 1 && y == side_now - 1);
        return p;
    endfunction

    // Advance the model by one accepted height word and queue its normals.
    task automatic predict_normals(logic [15:0] h, bit flat);
        normal_px_t got[$];
        side_now = (size_reg < 2) ? 2 : ((size_reg > MAX_SIZE) ? MAX_SIZE : size_reg);
        if (col_cnt >= side_now || row_cnt >= side_now) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        word_col = col_cnt;
        word_row = row_cnt;
        word_height = h;
        if (word_row >= 1) got.push_back(normal_of(word_col, word_row - 1));
        if (word_row == side_now - 1) begin
            if (word_col >= 1) got.push_back(normal_of(word_col - 1, word_row));
            if (word_col == side_now - 1) got.push_back(normal_of(word_col, word_row));
        end
        if (got.size() > 0) got[got.size() - 1].lst = 1'b1;
        foreach (got[i]) begin
            if (flat) begin
                got[i].red   = 8'd128;
                got[i].green = 8'd128;
                got[i].blue  = 8'd255;
            end
            pending_normals.push_back(got[i]);
        end
        row_two_above[word_col] = row_above[word_col];
        row_above[word_col] = h;
        col_cnt = word_col + 1;
        if (col_cnt >= side_now) begin
            col_cnt = 0;
            row_cnt = (word_row + 1 >= side_now) ? 0 : word_row + 1;
        end
    endtask

    // Sender: bursts of random length, separated by random gaps.
    task automatic send_height(logic [15:0] h, bit flat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        do @(posedge aclk); while (!s_tready);
        predict_normals(h, flat);
        words_sent++;
    endtask

    // Size writes only happen with the core drained. Words in the first row
    // give no output, so a fixed pause covers work still in flight.
    task automatic write_size(logic [10:0] v);
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_normals.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
    endtask

    function automatic logic [15:0] next_height(int mode, int unsigned x, int unsigned y,
                                                int sx, int sy, int base);
        int v;
        case (mode)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: begin
                v = base + int'(x) * sx + int'(y) * sy + int'($urandom_range(0, 64)) - 32;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    // Send a number of words in raster order with one texture per frame.
    task automatic send_frames(int unsigned words);
        int          mode, sx, sy, base;
        int unsigned s, x, y;
        s = (size_reg < 2) ? 2 : ((size_reg > MAX_SIZE) ? MAX_SIZE : size_reg);
        x = col_cnt;
        y = row_cnt;
        mode = 0; sx = 0; sy = 0; base = 0;
        for (int unsigned i = 0; i < words; i++) begin
            if (x >= s || y >= s) begin
                x = 0;
                y = 0;
            end
            if (x == 0 && y == 0 || i == 0) begin
                mode = $urandom_range(0, 5);
                sx   = int'($urandom_range(0, 4000)) - 2000;
                sy   = int'($urandom_range(0, 4000)) - 2000;
                base = $urandom_range(0, 65535);
            end
            send_height(next_height(mode, x, y, sx, sy, base), 1'b0);
            x++;
            if (x >= s) begin
                x = 0;
                y++;
            end
        end
    endtask

    // Receiver stall pattern: free running, random, or long stalls.
    int stall_mode;
    int stall_left;
    int pattern_cnt;
    always @(posedge aclk) begin
        pattern_cnt <= pattern_cnt + 1;
        if (pattern_cnt % 97 == 0) stall_mode <= $urandom_range(0, 2);
        if (stall_mode == 0) begin
            m_tready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_tready <= $urandom_range(0, 1);
        end else begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left <= $urandom_range(0, 30);
                m_tready <= 1'b1;
            end
        end
    end

    // Output checker: each word is matched against the oldest expectation.
    always @(posedge aclk) begin
        normal_px_t e;
        if (aresetn && m_tvalid && m_tready) begin
            normals_seen++;
            if (pending_normals.size() == 0) begin
                $error("output word with no expectation: %h", m_tdata);
                err_cnt++;
            end else begin
                e = pending_normals.pop_front();
                if (m_tdata[9:0] !== e.col) begin
                    $error("pixel_col expected %0d actual %0d", e.col, m_tdata[9:0]);
                    err_cnt++;
                end
                if (m_tdata[19:10] !== e.row) begin
                    $error("pixel_row expected %0d actual %0d", e.row, m_tdata[19:10]);
                    err_cnt++;
                end
                if (m_tdata[27:20] !== e.red) begin
                    $error("red expected %0d actual %0d", e.red, m_tdata[27:20]);
                    err_cnt++;
                end
                if (m_tdata[35:28] !== e.green) begin
                    $error("green expected %0d actual %0d", e.green, m_tdata[35:28]);
                    err_cnt++;
                end
                if (m_tdata[43:36] !== e.blue) begin
                    $error("blue expected %0d actual %0d", e.blue, m_tdata[43:36]);
                    err_cnt++;
                end
                if (m_tlast !== e.lst) begin
                    $error("last_of_run expected %0d actual %0d", e.lst, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== e.eof) begin
                    $error("end_of_frame expected %0d actual %0d", e.eof, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d words still expected", pending_normals.size());
        $display("DONE: errors detected");
        $finish;
    end

    stim_row_t   stim[$];
    int          drain;
    logic [10:0] sz;

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 11'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 16'd0;
        m_tready    = 1'b0;
        stall_mode  = 0;
        stall_left  = 0;
        pattern_cnt = 1;
        err_cnt     = 0;
        words_sent  = 0;
        normals_seen = 0;
        burst_left  = 0;
        col_cnt     = 0;
        row_cnt     = 0;
        size_reg    = 11'd1024;
        foreach (row_above[i]) begin
            row_above[i] = 16'd0;
            row_two_above[i] = 16'd0;
        end

        // Smallest image, flat at zero; then a steep checkerboard at full
        // scale; a size below the range; a three-by-three flat image at the top.
        stim.push_back('{1, 11'd2, 16'h0000, 1});
        repeat (3) stim.push_back('{0, 11'd2, 16'h0000, 1});
        stim.push_back('{0, 11'd2, 16'h0000, 0});
        stim.push_back('{0, 11'd2, 16'hFFFF, 0});
        stim.push_back('{0, 11'd2, 16'hFFFF, 0});
        stim.push_back('{0, 11'd2, 16'h0000, 0});
        stim.push_back('{1, 11'd0, 16'hFFFF, 0});
        stim.push_back('{0, 11'd0, 16'h0000, 0});
        stim.push_back('{0, 11'd0, 16'h0000, 0});
        stim.push_back('{0, 11'd0, 16'hFFFF, 0});
        stim.push_back('{1, 11'd3, 16'hFFFF, 1});
        repeat (8) stim.push_back('{0, 11'd3, 16'hFFFF, 1});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim[i]) begin
            if (stim[i].wr) write_size(stim[i].size);
            send_height(stim[i].height, stim[i].flat);
        end

        // A size above the range runs at the largest image for part of the
        // top row. Lowering the size mid-frame starts over. Random sizes stay
        // within the columns that the nine-column frame has filled.
        write_size(11'd2047);
        send_frames(40);
        write_size(11'd6);
        send_frames(6 * 6 * 2);
        write_size(11'd1);
        send_frames(4 * 3);
        write_size(11'd9);
        send_frames(20);
        write_size(11'd4);
        send_frames(4 * 4 * 3);
        repeat (5) begin
            sz = 11'($urandom_range(3, 9));
            write_size(sz);
            send_frames(sz * sz);
        end
        write_size(11'd5);
        send_frames(50);

        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_normals.size() > 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        if (pending_normals.size() > 0) begin
            $display("timeout with %0d words still expected", pending_normals.size());
            $display("DONE: errors detected");
            $finish;
        end
        repeat (100) @(posedge aclk);

        $display("Sent %0d height words and checked %0d normal words,", words_sent,
                 normals_seen);
        $display("over clamped sizes from 2 up to 1024 including mid-frame size changes.");
        if (err_cnt == 0 && pending_normals.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hnm_pkg.sv
hw/rtl/hnm_ram.sv
hw/rtl/hnm_front.sv
hw/rtl/hnm_queue.sv
hw/rtl/hnm_back.sv
hw/rtl/heightmap_normal_map_core.sv
hw/rtl/hnm_checker.sv
tb/heightmap_normal_map_core_test.sv
